### hdl/s2x_pkg.sv
package s2x_pkg;

    localparam int OUT_FRAC_BITS = 8;
    localparam int CURVE_DEPTH   = 256;
    localparam int CODE_W        = $clog2(CURVE_DEPTH);
    localparam int LIN_W         = 17;
    localparam int COEF_W        = 14;
    localparam int NUM_W         = 30;
    localparam int OUT_W         = 15;
    localparam int OUT_MAX       = 32767;
    localparam int LIN_FRAC      = 16;
    localparam int MAT_DIV       = 100;
    localparam int WIDE_W        = 320;

    typedef logic [LIN_W-1:0] t_lin;
    typedef logic [CURVE_DEPTH-1:0][LIN_W-1:0] t_curve;

    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] blue;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] red;
    } t_pix;

    typedef struct packed {
        logic            last;
        t_lin [2:0]      ch;
    } t_lin_pix;

    typedef struct packed {
        logic                  last;
        logic [2:0][NUM_W-1:0] row;
    } t_row_pix;

    typedef struct packed {
        logic                  last;
        logic [2:0][OUT_W-1:0] xyz;
    } t_xyz;

    function automatic logic [COEF_W-1:0] mat_coef(input int row, input int col);
        logic [COEF_W-1:0] c;
        case (row * 3 + col)
            0:       c = COEF_W'(4124);
            1:       c = COEF_W'(3576);
            2:       c = COEF_W'(1805);
            3:       c = COEF_W'(2126);
            4:       c = COEF_W'(7152);
            5:       c = COEF_W'(722);
            6:       c = COEF_W'(193);
            7:       c = COEF_W'(1192);
            default: c = COEF_W'(9505);
        endcase
        return c;
    endfunction

    // sRGB decode curve in Q1.16, exact rounding, evaluated at elaboration
    function automatic t_curve build_curve();
        t_curve           tab;
        logic [WIDE_W-1:0] base;
        logic [WIDE_W-1:0] rhs;
        logic [WIDE_W-1:0] t;
        int               c;
        int               i;
        int               k;
        int               lo;
        int               hi;
        int               mid;
        base = WIDE_W'(1);
        for (i = 0; i < 12; i++) begin
            base = base * WIDE_W'(269025);
        end
        for (c = 0; c < CURVE_DEPTH; c++) begin
            if (c * 100000 <= 1031475) begin
                tab[c] = LIN_W'((c * 6553600 + 164730) / 329460);
            end else begin
                rhs = WIDE_W'(1);
                for (i = 0; i < 12; i++) begin
                    rhs = rhs * WIDE_W'(1000 * c + 14025);
                end
                rhs = rhs << 85;
                lo  = 0;
                hi  = 65536;
                for (k = 0; k < 18; k++) begin
                    if (lo < hi) begin
                        mid = (lo + hi + 1) / 2;
                        t   = base;
                        for (i = 0; i < 5; i++) begin
                            t = t * WIDE_W'(2 * mid - 1);
                        end
                        if (t <= rhs) begin
                            lo = mid;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                end
                tab[c] = LIN_W'(lo);
            end
        end
        return tab;
    endfunction

    localparam t_curve CURVE_TAB = build_curve();

endpackage

### hdl/s2x_linearize.sv
module s2x_linearize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  s2x_pkg::t_pix     i_pix,
    output logic              o_valid,
    input  logic              i_ready,
    output s2x_pkg::t_lin_pix o_lin
);
    import s2x_pkg::*;

    logic     r_valid;
    t_lin_pix r_lin;
    t_lin_pix n_lin;
    logic     en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        n_lin.last  = i_pix.last;
        n_lin.ch[0] = CURVE_TAB[i_pix.red];
        n_lin.ch[1] = CURVE_TAB[i_pix.green];
        n_lin.ch[2] = CURVE_TAB[i_pix.blue];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_lin <= n_lin;
        end
    end

    assign o_valid = r_valid;
    assign o_lin   = r_lin;

endmodule

### hdl/s2x_matrix.sv
module s2x_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  s2x_pkg::t_lin_pix i_lin,
    output logic              o_valid,
    input  logic              i_ready,
    output s2x_pkg::t_row_pix o_row
);
    import s2x_pkg::*;

    logic                       r_prod_valid;
    logic                       r_prod_last;
    logic [2:0][2:0][NUM_W-1:0] r_prod;
    logic                       r_sum_valid;
    t_row_pix                   r_sum;
    logic                       en_prod;
    logic                       en_sum;

    assign en_sum  = !r_sum_valid || i_ready;
    assign en_prod = !r_prod_valid || en_sum;
    assign o_ready = en_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else begin
            if (en_prod) begin
                r_prod_valid <= i_valid;
            end
            if (en_sum) begin
                r_sum_valid <= r_prod_valid;
            end
        end
    end

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (en_prod && i_valid) begin
                    r_prod[gr][gc] <= NUM_W'(mat_coef(gr, gc) * (COEF_W + LIN_W)'(i_lin.ch[gc]));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_sum && r_prod_valid) begin
                r_sum.row[gr] <= NUM_W'((NUM_W + 2)'(r_prod[gr][0])
                                      + (NUM_W + 2)'(r_prod[gr][1])
                                      + (NUM_W + 2)'(r_prod[gr][2]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_prod && i_valid) begin
            r_prod_last <= i_lin.last;
        end
        if (en_sum && r_prod_valid) begin
            r_sum.last <= r_prod_last;
        end
    end

    assign o_valid = r_sum_valid;
    assign o_row   = r_sum;

endmodule

### hdl/s2x_scale.sv
module s2x_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  s2x_pkg::t_row_pix i_row,
    output logic              o_valid,
    input  logic              i_ready,
    output s2x_pkg::t_xyz     o_xyz
);
    import s2x_pkg::*;

    localparam int A_W         = NUM_W + OUT_FRAC_BITS + 1;
    localparam int B_W         = A_W - LIN_FRAC;
    localparam int RECIP_SHIFT = B_W + 7;
    localparam int RECIP_W     = RECIP_SHIFT - 6;
    localparam int P_W         = B_W + RECIP_W;
    localparam int Q_W         = P_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MAT_DIV - 1)) / 64'(MAT_DIV));
    localparam logic [A_W-1:0] HALF =
        A_W'((64'(MAT_DIV) << LIN_FRAC) / 64'd2);
    localparam int Y_FULL = MAT_DIV << OUT_FRAC_BITS;
    localparam logic [OUT_W-1:0] Y_LIM = OUT_W'((Y_FULL > OUT_MAX) ? OUT_MAX : Y_FULL);

    logic                   r_rnd_valid;
    logic                   r_rnd_last;
    logic [2:0][B_W-1:0]    r_rnd;
    logic                   r_mul_valid;
    logic                   r_mul_last;
    logic [2:0][P_W-1:0]    r_prod;
    logic                   r_out_valid;
    t_xyz                   r_out;
    t_xyz                   n_out;
    logic                   en_rnd;
    logic                   en_mul;
    logic                   en_out;
    logic [2:0][A_W-1:0]    rnd_sum;
    logic [2:0][Q_W-1:0]    quot;

    assign en_out  = !r_out_valid || i_ready;
    assign en_mul  = !r_mul_valid || en_out;
    assign en_rnd  = !r_rnd_valid || en_mul;
    assign o_ready = en_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_rnd) begin
                r_rnd_valid <= i_valid;
            end
            if (en_mul) begin
                r_mul_valid <= r_rnd_valid;
            end
            if (en_out) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_comb begin
        n_out.last = r_mul_last;
        for (int i = 0; i < 3; i++) begin
            rnd_sum[i] = (A_W'(i_row.row[i]) << OUT_FRAC_BITS) + HALF;
            quot[i]    = Q_W'(r_prod[i] >> RECIP_SHIFT);
            if (32'(quot[i]) > 32'(OUT_MAX)) begin
                n_out.xyz[i] = OUT_W'(OUT_MAX);
            end else begin
                n_out.xyz[i] = OUT_W'(quot[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_rnd && i_valid) begin
            r_rnd_last <= i_row.last;
            for (int i = 0; i < 3; i++) begin
                r_rnd[i] <= rnd_sum[i][A_W-1:LIN_FRAC];
            end
        end
        if (en_mul && r_rnd_valid) begin
            r_mul_last <= r_rnd_last;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= P_W'(r_rnd[i]) * P_W'(RECIP_MUL);
            end
        end
        if (en_out && r_mul_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_xyz   = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("result changed while stalled");

    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_valid && !en_out |=> r_mul_valid && $stable(r_prod))
        else $error("multiplier stage lost data under stall");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.xyz[1] <= Y_LIM)
        else $error("Y above full scale");

endmodule

### hdl/srgb_to_xyz_pixel.sv
// sRGB (8 bit per channel) to CIE XYZ D65 converter, six register stages.
// Throughput: one pixel per cycle while m_axis_tready is high; each stage refills as soon as it empties.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data holds.
// The decode curve is constant logic, so no fill pass follows reset.
module srgb_to_xyz_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // x_value[14:0], y_value[29:15], z_value[44:30], 0
    output logic        m_axis_tlast
);
    import s2x_pkg::*;

    t_pix     pix;
    t_lin_pix lin;
    t_row_pix row;
    t_xyz     xyz;
    logic     lin_valid;
    logic     lin_ready;
    logic     row_valid;
    logic     row_ready;

    always_comb begin
        pix.red   = s_axis_tdata[7:0];
        pix.green = s_axis_tdata[15:8];
        pix.blue  = s_axis_tdata[23:16];
        pix.last  = s_axis_tlast;
    end

    s2x_linearize u_linearize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (pix),
        .o_valid (lin_valid),
        .i_ready (lin_ready),
        .o_lin   (lin)
    );

    s2x_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lin_valid),
        .o_ready (lin_ready),
        .i_lin   (lin),
        .o_valid (row_valid),
        .i_ready (row_ready),
        .o_row   (row)
    );

    s2x_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (row_valid),
        .o_ready (row_ready),
        .i_row   (row),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_xyz   (xyz)
    );

    assign m_axis_tdata = {3'b000, xyz.xyz[2], xyz.xyz[1], xyz.xyz[0]};
    assign m_axis_tlast = xyz.last;

endmodule

### sim/tb_srgb_to_xyz_pixel.sv
module tb_srgb_to_xyz_pixel;

    import s2x_pkg::*;

    localparam int N_RANDOM   = 1325;
    localparam int DRAIN_LEFT = 600;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_WAIT  = 24;
    localparam longint unsigned MAT_SCALE = 64'd6553600;

    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct {
        logic [14:0] x_value;
        logic [14:0] y_value;
        logic [14:0] z_value;
        logic        last_out;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // x_value[14:0], y_value[29:15], z_value[44:30], 0
    logic        m_axis_tlast;

    t_pixel      pixels[$];
    t_result     xyz_expected[$];
    logic [16:0] decode_lut[256];
    int          n_total;
    int          sent_cnt = 0;
    int          n_errors = 0;
    bit          drain_done = 1'b0;

    srgb_to_xyz_pixel dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // exact test: (2y-1)^5 * 269025^12 <= (1000c+14025)^12 * 2^85
    function automatic bit gamma_bound_ok(int code, int y);
        logic [319:0] lhs;
        logic [319:0] rhs;
        int           i;
        if (y == 0) begin
            return 1'b1;
        end
        lhs = 320'd1;
        rhs = 320'd1;
        for (i = 0; i < 12; i++) begin
            lhs = lhs * 320'd269025;
            rhs = rhs * 320'(1000 * code + 14025);
        end
        for (i = 0; i < 5; i++) begin
            lhs = lhs * 320'(2 * y - 1);
        end
        rhs = rhs << 85;
        return lhs <= rhs;
    endfunction

    function automatic int linearize(int code);
        real v;
        int  y;
        if (code <= 10) begin
            return (code * 6553600 + 164730) / 329460;
        end
        v = (code / 255.0 + 0.055) / 1.055;
        y = $rtoi($pow(v, 2.4) * 65536.0 + 0.5);
        if (y > 65536) y = 65536;
        if (y < 0) y = 0;
        while (y < 65536 && gamma_bound_ok(code, y + 1)) y++;
        while (y > 0 && !gamma_bound_ok(code, y)) y--;
        return y;
    endfunction

    function automatic logic [14:0] to_fixed(longint unsigned num);
        longint unsigned v;
        v = ((num << OUT_FRAC_BITS) + MAT_SCALE / 2) / MAT_SCALE;
        if (v > OUT_MAX) v = OUT_MAX;
        return v[14:0];
    endfunction

    function automatic t_result xyz_of(logic [23:0] rgb, logic last);
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        t_result         res;
        r = decode_lut[rgb[7:0]];
        g = decode_lut[rgb[15:8]];
        b = decode_lut[rgb[23:16]];
        res.x_value  = to_fixed(4124 * r + 3576 * g + 1805 * b);
        res.y_value  = to_fixed(2126 * r + 7152 * g + 722 * b);
        res.z_value  = to_fixed(193 * r + 1192 * g + 9505 * b);
        res.last_out = last;
        return res;
    endfunction

    function automatic int send_idle_pct();
        int phase;
        phase = sent_cnt * 3 / n_total;
        return phase == 0 ? 11 : (phase == 1 ? 63 : 0);
    endfunction

    function automatic int recv_idle_pct();
        int phase;
        phase = sent_cnt * 3 / n_total;
        return phase == 0 ? 63 : (phase == 1 ? 11 : 0);
    endfunction

    function automatic t_pixel mk_pixel(int r, int g, int b, int last);
        t_pixel p;
        p.red   = r[7:0];
        p.green = g[7:0];
        p.blue  = b[7:0];
        p.last  = last[0];
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pixel p;
        bit     go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                xyz_expected.push_back(xyz_of(s_axis_tdata, s_axis_tlast));
                sent_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                go = pixels.size() > 0 && $urandom_range(99) >= send_idle_pct();
                // hold off once until the pipeline has drained
                if (!drain_done && pixels.size() == DRAIN_LEFT) begin
                    if (xyz_expected.size() == 0) begin
                        drain_done = 1'b1;
                    end else begin
                        go = 1'b0;
                    end
                end
                if (go) begin
                    p = pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {p.blue, p.green, p.red};
                    s_axis_tlast  <= p.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (xyz_expected.size() == 0) begin
                    $error("unexpected result transfer: tdata=%h tlast=%b",
                           m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    want = xyz_expected.pop_front();
                    if (m_axis_tdata[14:0] !== want.x_value) begin
                        $error("x_value: expected %0d, got %0d",
                               want.x_value, m_axis_tdata[14:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[29:15] !== want.y_value) begin
                        $error("y_value: expected %0d, got %0d",
                               want.y_value, m_axis_tdata[29:15]);
                        n_errors++;
                    end
                    if (m_axis_tdata[44:30] !== want.z_value) begin
                        $error("z_value: expected %0d, got %0d",
                               want.z_value, m_axis_tdata[44:30]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last_out) begin
                        $error("last_out: expected %0d, got %0d",
                               want.last_out, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct();
        end
    end

    initial begin
        int  c;
        int  k;
        int  stall;
        bit  timed_out;
        for (c = 0; c < 256; c++) begin
            decode_lut[c] = 17'(linearize(c));
        end

        pixels.push_back(mk_pixel(0, 0, 0, 0));
        pixels.push_back(mk_pixel(255, 255, 255, 0));
        pixels.push_back(mk_pixel(255, 0, 0, 0));
        pixels.push_back(mk_pixel(0, 255, 0, 0));
        pixels.push_back(mk_pixel(0, 0, 255, 1));
        pixels.push_back(mk_pixel(10, 10, 10, 0));
        pixels.push_back(mk_pixel(11, 11, 11, 0));
        pixels.push_back(mk_pixel(10, 11, 1, 0));
        pixels.push_back(mk_pixel(1, 1, 1, 1));
        pixels.push_back(mk_pixel(254, 254, 254, 0));
        pixels.push_back(mk_pixel(128, 128, 128, 0));
        pixels.push_back(mk_pixel(255, 0, 255, 0));
        pixels.push_back(mk_pixel(0, 255, 255, 1));
        pixels.push_back(mk_pixel(255, 255, 0, 0));
        pixels.push_back(mk_pixel(170, 85, 51, 1));
        pixels.push_back(mk_pixel(85, 170, 204, 0));
        pixels.push_back(mk_pixel(12, 9, 200, 1));
        for (k = 0; k < N_RANDOM; k++) begin
            pixels.push_back(mk_pixel($urandom_range(255), $urandom_range(255),
                                      $urandom_range(255),
                                      $urandom_range(15) == 0 ? 1 : 0));
        end
        n_total = pixels.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall = 0;
        timed_out = 1'b0;
        while (!(pixels.size() == 0 && !s_axis_tvalid && xyz_expected.size() == 0)
               && !timed_out) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall = 0;
            end else begin
                stall++;
            end
            if (stall >= STALL_MAX) timed_out = 1'b1;
        end

        if (timed_out) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            repeat (TAIL_WAIT) @(posedge i_clk);
            if (n_errors == 0) begin
                $display("== PASS ==");
            end else begin
                $display("== FAIL ==");
            end
            $finish;
        end
    end

endmodule

### filelist.f
hdl/s2x_pkg.sv
hdl/s2x_linearize.sv
hdl/s2x_matrix.sv
hdl/s2x_scale.sv
hdl/srgb_to_xyz_pixel.sv
sim/tb_srgb_to_xyz_pixel.sv
